>>> hdl/dbs_pkg.sv
package dbs_pkg;

  localparam int MaxDetsDef = 64;
  localparam int DataW      = 88;
  localparam int CoordW     = 16;
  localparam int EdgeW      = CoordW + 1;
  localparam int InterW     = 2 * EdgeW;
  localparam int AreaW      = 2 * CoordW;
  localparam int UnionW     = AreaW + 1;
  localparam int ThrW       = 16;
  localparam int MulAW      = UnionW;
  localparam int MulBW      = EdgeW;
  localparam int ProdW      = MulAW + MulBW;
  localparam int AddrW      = 3;

  typedef struct packed {
    logic [7:0]        cls;
    logic [15:0]       score;
    logic [CoordW-1:0] h;
    logic [CoordW-1:0] w;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x;
  } det_t;

  typedef enum logic {
    REG_NMS_EN  = 1'b0,
    REG_IOU_THR = 1'b1
  } reg_idx_e;

  typedef enum logic [4:0] {
    S_LOAD,
    S_START,
    S_F1,
    S_GEOM,
    S_MI,
    S_MA,
    S_MB,
    S_UNI,
    S_MT,
    S_DEC,
    S_P2,
    S_F2,
    S_CONT,
    S_FIND,
    S_ESCAN,
    S_EF,
    S_EOUT,
    S_EMPTY
  } state_e;

endpackage

>>> hdl/dbs_store.sv
module dbs_store
  import dbs_pkg::*;
#(
  parameter int Depth = MaxDetsDef,
  parameter int AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  det_t          wdata_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output det_t          rdata_a_o,
  output det_t          rdata_b_o
);

  det_t mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

>>> hdl/dbs_arith.sv
module dbs_arith
  import dbs_pkg::*;
(
  input  logic             clk_i,
  input  logic [MulAW-1:0] op_a_i,
  input  logic [MulBW-1:0] op_b_i,
  output logic [ProdW-1:0] prod_o
);

  always_ff @(posedge clk_i) begin
    prod_o <= ProdW'(op_a_i) * ProdW'(op_b_i);
  end

endmodule

>>> hdl/dbs_seq.sv
module dbs_seq
  import dbs_pkg::*;
#(
  parameter int MaxDets = MaxDetsDef,
  parameter int AW      = 6,
  parameter int CW      = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             nms_en_i,
  input  logic [ThrW-1:0]  iou_thr_i,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  input  logic             s_last_i,
  output logic             st_we_o,
  output logic [AW-1:0]    st_waddr_o,
  output logic [AW-1:0]    st_raddr_a_o,
  output logic [AW-1:0]    st_raddr_b_o,
  input  det_t             st_rdata_a_i,
  input  det_t             st_rdata_b_i,
  output logic [MulAW-1:0] mul_a_o,
  output logic [MulBW-1:0] mul_b_o,
  input  logic [ProdW-1:0] prod_i,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output det_t             m_data_o,
  output logic             m_user_o,
  output logic             m_last_o
);

  state_e              state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [AW-1:0]       i_q, i_d, j_q, j_d, k_q, k_d, last_q, last_d;
  logic [MaxDets-1:0]  drop_q, drop_d, mark_q, mark_d;
  logic [EdgeW-1:0]    iw_q, iw_d, ih_q, ih_d;
  logic [InterW-1:0]   inter_q, inter_d;
  logic [AreaW-1:0]    area_q, area_d;
  logic [UnionW-1:0]   uni_q, uni_d;
  det_t                out_q, out_d;
  logic                ov_q, ov_d, ou_q, ou_d, ol_q, ol_d;

  logic [CW-1:0]       cm1, cm2;
  logic [EdgeW-1:0]    ar, ab, br, bb, l, t, r, d;
  logic                c_ij, c_ji, eq, slot, surv, is_stage1;

  function automatic logic holds(det_t o, det_t n);
    logic [EdgeW-1:0] orr, ob, nr, nb;
    orr = EdgeW'(o.x) + EdgeW'(o.w);
    ob  = EdgeW'(o.y) + EdgeW'(o.h);
    nr  = EdgeW'(n.x) + EdgeW'(n.w);
    nb  = EdgeW'(n.y) + EdgeW'(n.h);
    return (o.x <= n.x) && (o.y <= n.y) && (orr >= nr) && (ob >= nb);
  endfunction

  assign cm1 = cnt_q - CW'(1);
  assign cm2 = cnt_q - CW'(2);
  assign ar  = EdgeW'(st_rdata_a_i.x) + EdgeW'(st_rdata_a_i.w);
  assign ab  = EdgeW'(st_rdata_a_i.y) + EdgeW'(st_rdata_a_i.h);
  assign br  = EdgeW'(st_rdata_b_i.x) + EdgeW'(st_rdata_b_i.w);
  assign bb  = EdgeW'(st_rdata_b_i.y) + EdgeW'(st_rdata_b_i.h);
  assign l   = EdgeW'((st_rdata_a_i.x > st_rdata_b_i.x) ? st_rdata_a_i.x : st_rdata_b_i.x);
  assign t   = EdgeW'((st_rdata_a_i.y > st_rdata_b_i.y) ? st_rdata_a_i.y : st_rdata_b_i.y);
  assign r   = (ar < br) ? ar : br;
  assign d   = (ab < bb) ? ab : bb;
  assign c_ij = holds(st_rdata_a_i, st_rdata_b_i);
  assign c_ji = holds(st_rdata_b_i, st_rdata_a_i);
  assign eq   = (st_rdata_a_i.cls == st_rdata_b_i.cls);
  assign slot = !ov_q || m_ready_i;
  assign surv = !drop_q[k_q] && !mark_q[k_q];
  assign is_stage1 = (state_q == S_DEC);

  assign s_ready_o    = (state_q == S_LOAD);
  assign st_we_o      = s_valid_i && s_ready_o && (cnt_q < CW'(MaxDets));
  assign st_waddr_o   = cnt_q[AW-1:0];
  assign st_raddr_a_o = i_q;
  assign st_raddr_b_o = j_q;
  assign m_valid_o    = ov_q;
  assign m_data_o     = out_q;
  assign m_user_o     = ou_q;
  assign m_last_o     = ol_q;

  always_comb begin
    logic adv_j, adv_i;
    state_d = state_q;
    cnt_d   = cnt_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    last_d  = last_q;
    drop_d  = drop_q;
    mark_d  = mark_q;
    iw_d    = iw_q;
    ih_d    = ih_q;
    inter_d = inter_q;
    area_d  = area_q;
    uni_d   = uni_q;
    out_d   = out_q;
    ov_d    = ov_q && !m_ready_i;
    ou_d    = ou_q;
    ol_d    = ol_q;
    mul_a_o = '0;
    mul_b_o = '0;
    adv_j   = 1'b0;
    adv_i   = 1'b0;

    unique case (state_q)
      S_LOAD: begin
        if (s_valid_i) begin
          if (st_we_o) begin
            cnt_d = cnt_q + CW'(1);
          end
          if (s_last_i) begin
            state_d = S_START;
          end
        end
      end
      S_START: begin
        if (cnt_q >= CW'(2)) begin
          i_d     = cm1[AW-1:0];
          j_d     = cm2[AW-1:0];
          state_d = nms_en_i ? S_F1 : S_P2;
        end else begin
          state_d = S_FIND;
          k_d     = cm1[AW-1:0];
        end
      end
      S_F1: state_d = S_GEOM;
      S_GEOM: begin
        iw_d    = (r > l) ? r - l : '0;
        ih_d    = (d > t) ? d - t : '0;
        state_d = S_MI;
      end
      S_MI: begin
        mul_a_o = MulAW'(iw_q);
        mul_b_o = ih_q;
        state_d = S_MA;
      end
      S_MA: begin
        inter_d = prod_i[InterW-1:0];
        mul_a_o = MulAW'(st_rdata_a_i.w);
        mul_b_o = MulBW'(st_rdata_a_i.h);
        state_d = S_MB;
      end
      S_MB: begin
        area_d  = prod_i[AreaW-1:0];
        mul_a_o = MulAW'(st_rdata_b_i.w);
        mul_b_o = MulBW'(st_rdata_b_i.h);
        state_d = S_UNI;
      end
      S_UNI: begin
        uni_d   = UnionW'(area_q) + UnionW'(prod_i[AreaW-1:0]) - UnionW'(inter_q);
        state_d = S_MT;
      end
      S_MT: begin
        mul_a_o = uni_q;
        mul_b_o = MulBW'(iou_thr_i);
        state_d = S_DEC;
      end
      S_DEC: begin
        if ((uni_q != '0) && ({inter_q, 16'h0} > prod_i)) begin
          if ($signed(st_rdata_a_i.score) < $signed(st_rdata_b_i.score)) begin
            drop_d[i_q] = 1'b1;
          end else begin
            drop_d[j_q] = 1'b1;
          end
        end
        adv_j = 1'b1;
      end
      S_P2: begin
        if (drop_q[i_q]) begin
          adv_i = 1'b1;
        end else if (drop_q[j_q]) begin
          adv_j = 1'b1;
        end else begin
          state_d = S_F2;
        end
      end
      S_F2: state_d = S_CONT;
      S_CONT: begin
        if (c_ij) begin
          if (eq) begin
            mark_d[i_q] = 1'b1;
          end
          adv_i = 1'b1;
        end else if (c_ji) begin
          if (eq) begin
            mark_d[j_q] = 1'b1;
          end
          adv_i = 1'b1;
        end else begin
          adv_j = 1'b1;
        end
      end
      S_FIND: begin
        if (cnt_q == '0) begin
          state_d = S_EMPTY;
        end else if (surv) begin
          last_d  = k_q;
          k_d     = '0;
          state_d = S_ESCAN;
        end else if (k_q == '0) begin
          state_d = S_EMPTY;
        end else begin
          k_d = k_q - AW'(1);
        end
      end
      S_ESCAN: begin
        if (surv) begin
          i_d     = k_q;
          state_d = S_EF;
        end else begin
          k_d = k_q + AW'(1);
        end
      end
      S_EF: state_d = S_EOUT;
      S_EOUT: begin
        if (slot) begin
          out_d = st_rdata_a_i;
          ov_d  = 1'b1;
          ou_d  = 1'b1;
          ol_d  = (k_q == last_q);
          if (k_q == last_q) begin
            state_d = S_LOAD;
            cnt_d   = '0;
            drop_d  = '0;
            mark_d  = '0;
          end else begin
            k_d     = k_q + AW'(1);
            state_d = S_ESCAN;
          end
        end
      end
      S_EMPTY: begin
        if (slot) begin
          out_d   = '0;
          ov_d    = 1'b1;
          ou_d    = 1'b0;
          ol_d    = 1'b1;
          state_d = S_LOAD;
          cnt_d   = '0;
          drop_d  = '0;
          mark_d  = '0;
        end
      end
      default: state_d = S_LOAD;
    endcase

    if (adv_j && (j_q != '0)) begin
      j_d     = j_q - AW'(1);
      state_d = is_stage1 ? S_F1 : S_P2;
    end else if (adv_j || adv_i) begin
      if (i_q == AW'(1)) begin
        if (is_stage1) begin
          i_d     = cm1[AW-1:0];
          j_d     = cm2[AW-1:0];
          state_d = S_P2;
        end else begin
          k_d     = cm1[AW-1:0];
          state_d = S_FIND;
        end
      end else begin
        i_d     = i_q - AW'(1);
        j_d     = i_q - AW'(2);
        state_d = is_stage1 ? S_F1 : S_P2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      drop_q  <= '0;
      mark_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      drop_q  <= drop_d;
      mark_q  <= mark_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q     <= i_d;
    j_q     <= j_d;
    k_q     <= k_d;
    last_q  <= last_d;
    iw_q    <= iw_d;
    ih_q    <= ih_d;
    inter_q <= inter_d;
    area_q  <= area_d;
    uni_q   <= uni_d;
    out_q   <= out_d;
    ou_q    <= ou_d;
    ol_q    <= ol_d;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MaxDets))
    else $error("detection count beyond capacity");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GEOM || state_q == S_DEC || state_q == S_CONT) |-> (j_q < i_q))
    else $error("pair indexes out of order");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !ou_q) |-> ol_q)
    else $error("empty-frame result without last");

  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_d && !ov_q && ol_d) |=> (state_q == S_LOAD && cnt_q == '0))
    else $error("frame state not cleared after final result");

endmodule

>>> hdl/detection_box_suppression.sv
// Detection box suppression with overlap and containment stages.
// Detections of one frame arrive as requests on the s_axis channel, one per
// cycle while s_axis_tready is high; s_axis_tlast closes the frame. Up to
// MaxDets detections are kept, later ones in the frame are ignored.
// After the closing request the block drops ready and runs its sequencer.
// Overlap suppression, when enabled, visits every box pair in turn, and
// the single shared multiplier forms the intersection, both areas and
// the threshold product one after another. Containment removal then
// checks pairs of kept boxes. Emission first finds the last survivor,
// then scans the boxes in order and sends each survivor; results leave
// on m_axis, the final one with m_axis_tlast high. A frame with no
// survivor gives one result with m_axis_tuser low and tlast high. The
// output register holds a result while m_axis_tready is low and the
// sequencer waits on it; the next frame is accepted as soon as the final
// result sits in that register.
// The APB port holds nms_enable at address 0 and iou_threshold at 4; write
// them only while the block is idle. Reset sets nms_enable to 1, the
// threshold to one half, and empties the frame.
module detection_box_suppression
  import dbs_pkg::*;
#(
  parameter int MaxDets = MaxDetsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // box_x, box_y, box_w, box_h, score, class_id
  input  logic [DataW-1:0] s_axis_tdata,
  input  logic             s_axis_tlast,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // out_x, out_y, out_w, out_h, out_score, out_class
  output logic [DataW-1:0] m_axis_tdata,
  // out_valid
  output logic             m_axis_tuser,
  output logic             m_axis_tlast
);

  localparam int AW = (MaxDets > 1) ? $clog2(MaxDets) : 1;
  localparam int CW = $clog2(MaxDets + 1);

  logic             nms_en_q;
  logic [ThrW-1:0]  thr_q;
  reg_idx_e         idx;
  logic             st_we;
  logic [AW-1:0]    waddr, ra, rb;
  det_t             rda, rdb, mdata;
  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [ProdW-1:0] prod;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nms_en_q <= 1'b1;
      thr_q    <= ThrW'(32768);
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_NMS_EN:  nms_en_q <= pwdata[0];
        REG_IOU_THR: thr_q    <= pwdata[ThrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_NMS_EN:  prdata = {31'b0, nms_en_q};
      REG_IOU_THR: prdata = {16'b0, thr_q};
      default:     prdata = '0;
    endcase
  end

  dbs_store #(.Depth(MaxDets), .AW(AW)) u_store (
    .clk_i     (clk_i),
    .we_i      (st_we),
    .waddr_i   (waddr),
    .wdata_i   (det_t'(s_axis_tdata)),
    .raddr_a_i (ra),
    .raddr_b_i (rb),
    .rdata_a_o (rda),
    .rdata_b_o (rdb)
  );

  dbs_arith u_arith (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (prod)
  );

  dbs_seq #(.MaxDets(MaxDets), .AW(AW), .CW(CW)) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .nms_en_i     (nms_en_q),
    .iou_thr_i    (thr_q),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_last_i     (s_axis_tlast),
    .st_we_o      (st_we),
    .st_waddr_o   (waddr),
    .st_raddr_a_o (ra),
    .st_raddr_b_o (rb),
    .st_rdata_a_i (rda),
    .st_rdata_b_i (rdb),
    .mul_a_o      (mul_a),
    .mul_b_o      (mul_b),
    .prod_i       (prod),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_o     (mdata),
    .m_user_o     (m_axis_tuser),
    .m_last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = DataW'(mdata);

endmodule

>>> sim/tb_detection_box_suppression.sv
`timescale 1ns / 100ps

module tb_detection_box_suppression;
  import dbs_pkg::*;

  typedef struct {
    logic [15:0] x, y, w, h;
    logic [15:0] score;
    logic [7:0]  cls;
  } tb_det_t;

  typedef struct {
    logic        valid;
    logic [87:0] data;
    logic        last;
  } surv_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [DataW-1:0] s_axis_tdata = '0;
  logic             s_axis_tlast = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [DataW-1:0] m_axis_tdata;
  logic             m_axis_tuser;
  logic             m_axis_tlast;

  tb_det_t frame_dets[$];
  surv_t   survivors_due[$];
  logic    nms_on = 1'b1;
  logic [15:0] iou_thr = 16'h8000;
  int     send_idle_pct = 0, recv_idle_pct = 0;
  int     mismatches = 0;
  longint cycles = 0;
  bit     failed = 1'b0;

  always #1 clk_i = ~clk_i;

  detection_box_suppression u_top (.*);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 64'd3_000_000) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    surv_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (survivors_due.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", m_axis_tdata);
      end else begin
        e = survivors_due.pop_front();
        if (e.valid !== m_axis_tuser || e.data !== m_axis_tdata ||
            e.last !== m_axis_tlast) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: exp v=%b d=%h l=%b got v=%b d=%h l=%b", e.valid, e.data,
                     e.last, m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  function automatic bit boxes_overlap(tb_det_t a, tb_det_t b);
    logic [16:0] l, t, r, d, ar, ab, br, bb;
    logic [33:0] inter, uni;
    inter = '0;
    ar = 17'(a.x) + 17'(a.w); ab = 17'(a.y) + 17'(a.h);
    br = 17'(b.x) + 17'(b.w); bb = 17'(b.y) + 17'(b.h);
    l = 17'((a.x > b.x) ? a.x : b.x);
    t = 17'((a.y > b.y) ? a.y : b.y);
    r = (ar < br) ? ar : br;
    d = (ab < bb) ? ab : bb;
    if (r > l && d > t) inter = 34'(r - l) * 34'(d - t);
    uni = 34'(a.w) * 34'(a.h) + 34'(b.w) * 34'(b.h) - inter;
    if (uni == 0) return 1'b0;
    return ({inter, 16'h0} > 50'(iou_thr) * 50'(uni));
  endfunction

  function automatic bit box_holds(tb_det_t o, tb_det_t n);
    return o.x <= n.x && o.y <= n.y && 17'(o.x) + 17'(o.w) >= 17'(n.x) + 17'(n.w) &&
           17'(o.y) + 17'(o.h) >= 17'(n.y) + 17'(n.h);
  endfunction

  task automatic predict_survivors();
    int  n, m, kept[$];
    bit  dropped[64], contained[64];
    tb_det_t a, b;
    surv_t s;
    n = frame_dets.size();
    foreach (dropped[i]) begin dropped[i] = 0; contained[i] = 0; end
    if (nms_on)
      for (int i = n - 1; i >= 0; i--)
        for (int j = i - 1; j >= 0; j--)
          if (boxes_overlap(frame_dets[i], frame_dets[j])) begin
            if ($signed(frame_dets[i].score) < $signed(frame_dets[j].score)) dropped[i] = 1;
            else dropped[j] = 1;
          end
    for (int i = 0; i < n; i++) if (!dropped[i]) kept = {kept, i};
    m = kept.size();
    for (int i = m - 1; i >= 0; i--)
      for (int j = i - 1; j >= 0; j--) begin
        a = frame_dets[kept[i]]; b = frame_dets[kept[j]];
        if (box_holds(a, b)) begin
          if (a.cls == b.cls) contained[i] = 1;
          break;
        end
        if (box_holds(b, a)) begin
          if (a.cls == b.cls) contained[j] = 1;
          break;
        end
      end
    s.last = 0;
    for (int i = 0; i < m; i++) begin
      if (contained[i]) continue;
      a = frame_dets[kept[i]];
      s.valid = 1;
      s.data = {a.cls, a.score, a.h, a.w, a.y, a.x};
      survivors_due = {survivors_due, s};
      n = -1;
    end
    if (n != -1) begin
      s.valid = 0; s.data = '0;
      survivors_due = {survivors_due, s};
    end
    s = survivors_due[$];
    s.last = 1;
    survivors_due[$] = s;
    frame_dets.delete();
  endtask

  task automatic send_det(tb_det_t d, bit last);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {d.cls, d.score, d.h, d.w, d.y, d.x};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (frame_dets.size() < 64) frame_dets = {frame_dets, d};
    if (last) predict_survivors();
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (survivors_due.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    drain();
    psel <= 1; pwrite <= 1; paddr <= AddrW'(4 * idx); pwdata <= val;
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (idx == REG_NMS_EN) nms_on = val[0];
    else iou_thr = val[15:0];
  endtask

  function automatic tb_det_t rand_det(int span);
    tb_det_t d;
    d.x = 16'($urandom_range(span)); d.y = 16'($urandom_range(span));
    d.w = 16'($urandom_range(span)); d.h = 16'($urandom_range(span));
    d.score = 16'($urandom); d.cls = 8'($urandom_range(3));
    if ($urandom_range(9) == 0) begin
      d.x = 16'($urandom); d.y = 16'($urandom); d.w = 16'($urandom);
      d.h = 16'($urandom); d.cls = 8'($urandom);
    end
    return d;
  endfunction

  task automatic send_frame(int len, int span);
    for (int i = 0; i < len; i++) send_det(rand_det(span), i == len - 1);
  endtask

  task automatic test_directed();
    tb_det_t d;
    d = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 8'hFF};
    send_det(d, 1);
    d = '{16'h0, 16'h0, 16'h0, 16'h0, 16'h8000, 8'h00};
    send_det(d, 1);
    d = '{16'd10, 16'd10, 16'd100, 16'd100, 16'h0100, 8'd1};
    send_det(d, 0);
    d = '{16'd12, 16'd12, 16'd90, 16'd90, 16'h0100, 8'd1};
    send_det(d, 0);
    d = '{16'd20, 16'd20, 16'd10, 16'd10, 16'h0200, 8'd2};
    send_det(d, 0);
    d = '{16'd0, 16'd0, 16'd200, 16'd200, 16'hFF00, 8'd2};
    send_det(d, 1);
    d = '{16'd10, 16'd10, 16'd50, 16'd50, 16'h0100, 8'd5};
    send_det(d, 0);
    send_det(d, 1);
  endtask

  task automatic test_overflow();
    send_frame(70, 4000);
  endtask

  task automatic test_random(int items);
    int sent, len;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      send_frame(len, $urandom_range(1) ? 200 : 2000);
      sent += len;
    end
  endtask

  task automatic test_config();
    write_reg(REG_NMS_EN, 0);
    test_random(25);
    write_reg(REG_NMS_EN, 1);
    write_reg(REG_IOU_THR, 0);
    test_random(25);
    write_reg(REG_IOU_THR, 32'hFFFF);
    test_random(25);
    write_reg(REG_IOU_THR, 32'h4000);
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_overflow();
    send_idle_pct = 21; recv_idle_pct = 47;
    test_random(40);
    drain();
    test_config();
    send_idle_pct = 47; recv_idle_pct = 21;
    test_random(40);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(40);
    drain();
    if (!failed && survivors_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/dbs_pkg.sv
hdl/dbs_store.sv
hdl/dbs_arith.sv
hdl/dbs_seq.sv
hdl/detection_box_suppression.sv
sim/tb_detection_box_suppression.sv
